FILE: rtl/gbte_pkg.sv
// Shared widths, command codes and status codes of the gap-buffer text editor core.
package gbte_pkg;

    // Field widths of the transaction ports.
    localparam int CMD_W  = 2;
    localparam int POS_W  = 13;
    localparam int CH_W   = 8;
    localparam int STAT_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_AT     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BOUNDARY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CURSOR   = 2'd3;

    // Character constants.
    localparam logic [CH_W-1:0] NEWLINE_CH = 8'h0A;
    localparam logic [CH_W-1:0] NO_CHAR    = 8'hFF;

endpackage

FILE: rtl/gap_buffer_text_editor_core.sv
// Gap-buffer text editor core: fixed-capacity text store with a sequenced gap mover and scanner.
//
// This core keeps up to CAPACITY characters in a single-port-style byte memory organized as a
// gap buffer, and executes one command transaction at a time: insert, delete before the cursor,
// delete at the cursor, or query. Every command produces exactly one result transaction. The
// input side stalls from the moment a command is taken until its result has been handed off on
// the output side. A rejected command (cursor beyond the text, insert into a full store,
// delete at a text boundary) goes to its result without touching the store. An edit first
// moves the gap to the cursor one character at a time, each by a read and then a write, and
// a delete then captures the removed character from the registered read. A query runs three
// scans over the memory (back to the line start, forward to the line end, back to the start
// of the previous line), each examining one character by a read and then a check. Moves and
// scans share the single memory read port; every read is registered and checked in the
// following cycle. The store has no reset and needs no clearing pass: only entries that were
// written are ever read.
module gap_buffer_text_editor_core #(
    parameter int CAPACITY = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gbte_pkg::CMD_W-1:0]    cmd,
    input  logic [gbte_pkg::POS_W-1:0]    cursor,
    input  logic [gbte_pkg::CH_W-1:0]     ch,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gbte_pkg::STAT_W-1:0]   status,
    output logic [gbte_pkg::CH_W-1:0]     ch_out,
    output logic [gbte_pkg::POS_W-1:0]    text_length,
    output logic [gbte_pkg::POS_W-1:0]    line_begin,
    output logic [gbte_pkg::POS_W-1:0]    line_stop,
    output logic [gbte_pkg::POS_W-1:0]    column,
    output logic [gbte_pkg::POS_W-1:0]    line_length,
    output logic [gbte_pkg::POS_W-1:0]    next_line_begin,
    output logic [gbte_pkg::POS_W-1:0]    prev_line_stop,
    output logic [gbte_pkg::POS_W-1:0]    prev_line_begin
);

    // Positions run from 0 to CAPACITY inclusive; memory addresses stop one short.
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int OW = gbte_pkg::POS_W;
    localparam int CW = gbte_pkg::CH_W;
    localparam int SW = gbte_pkg::STAT_W;
    localparam int XW = (PW > OW) ? PW : OW;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [PW-1:0] ONE_P = PW'(1);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOVE_RD  = 4'd1;
    localparam logic [3:0] S_MOVE_WR  = 4'd2;
    localparam logic [3:0] S_EDIT_CAP = 4'd3;
    localparam logic [3:0] S_BK_RD    = 4'd4;
    localparam logic [3:0] S_BK_CHK   = 4'd5;
    localparam logic [3:0] S_FW_RD    = 4'd6;
    localparam logic [3:0] S_FW_CHK   = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    // Control registers.
    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] gap_low_reg, gap_low_next;
    logic [PW-1:0] gap_high_reg, gap_high_next;
    logic          out_valid_reg, out_valid_next;
    logic          second_reg, second_next;

    // Command and scan registers.
    logic [gbte_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] b_reg, b_next;
    logic [PW-1:0] e_reg, e_next;
    logic [PW-1:0] ps_reg, ps_next;

    // Result registers.
    logic [SW-1:0] status_reg, status_next;
    logic [CW-1:0] ch_out_reg, ch_out_next;
    logic [OW-1:0] tl_reg, tl_next;
    logic [OW-1:0] lb_reg, lb_next;
    logic [OW-1:0] ls_reg, ls_next;
    logic [OW-1:0] col_reg, col_next;
    logic [OW-1:0] ll_reg, ll_next;
    logic [OW-1:0] nlb_reg, nlb_next;
    logic [OW-1:0] pls_reg, pls_next;
    logic [OW-1:0] plb_reg, plb_next;

    // Text store and its ports.
    logic [CW-1:0] store_mem [CAPACITY];
    logic [CW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Shared address arithmetic.
    logic [PW-1:0] gap_span;
    logic [PW-1:0] text_len;
    logic [PW-1:0] scan_pos;
    logic [AW-1:0] scan_addr;
    logic          accept;
    logic          bk_fin;
    logic [PW-1:0] bk_val;
    logic          fw_fin;
    logic [PW-1:0] fw_val;

    assign gap_span = gap_high_reg - gap_low_reg;
    assign text_len = CAP_P - gap_span;

    // The backward scan looks at the character left of the scan pointer, the forward scan at
    // the character under it. Logical positions past the gap are offset by the gap size.
    assign scan_pos  = (state_reg == S_BK_RD) ? (p_reg - ONE_P) : p_reg;
    assign scan_addr = (scan_pos < gap_low_reg) ? AW'(scan_pos) : AW'(scan_pos + gap_span);

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        gap_low_next   = gap_low_reg;
        gap_high_next  = gap_high_reg;
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        ch_next        = ch_reg;
        p_next         = p_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        ps_next        = ps_reg;
        status_next    = status_reg;
        ch_out_next    = ch_out_reg;
        tl_next        = tl_reg;
        lb_next        = lb_reg;
        ls_next        = ls_reg;
        col_next       = col_reg;
        ll_next        = ll_reg;
        nlb_next       = nlb_reg;
        pls_next       = pls_reg;
        plb_next       = plb_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(gap_low_reg);
        mem_wdata      = rd_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = scan_addr;
        bk_fin         = 1'b0;
        bk_val         = p_reg;
        fw_fin         = 1'b0;
        fw_val         = p_reg;

        // The result register is released as soon as the downstream side takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd;
                    cur_next    = PW'(cursor);
                    ch_next     = ch;
                    status_next = gbte_pkg::STAT_OK;
                    ch_out_next = '0;
                    lb_next     = '0;
                    ls_next     = '0;
                    col_next    = '0;
                    ll_next     = '0;
                    nlb_next    = '0;
                    pls_next    = '0;
                    plb_next    = '0;
                    if (XW'(cursor) > XW'(text_len))
                    begin
                        status_next = gbte_pkg::STAT_CURSOR;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        unique case (cmd)
                            gbte_pkg::CMD_INSERT:
                            begin
                                if (gap_span == '0)
                                begin
                                    status_next = gbte_pkg::STAT_FULL;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    state_next = S_MOVE_RD;
                                end
                            end
                            gbte_pkg::CMD_DEL_BEFORE:
                            begin
                                if (cursor == '0)
                                begin
                                    status_next = gbte_pkg::STAT_BOUNDARY;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    state_next = S_MOVE_RD;
                                end
                            end
                            gbte_pkg::CMD_DEL_AT:
                            begin
                                if (XW'(cursor) == XW'(text_len))
                                begin
                                    status_next = gbte_pkg::STAT_BOUNDARY;
                                    ch_out_next = gbte_pkg::NO_CHAR;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    state_next = S_MOVE_RD;
                                end
                            end
                            gbte_pkg::CMD_QUERY:
                            begin
                                // The character code stays at the no-character value
                                // unless the forward scan reads a character at the cursor.
                                ch_out_next = gbte_pkg::NO_CHAR;
                                p_next      = PW'(cursor);
                                second_next = 1'b0;
                                state_next  = S_BK_RD;
                            end
                        endcase
                    end
                end
            end

            S_MOVE_RD:
            begin
                if (gap_low_reg > cur_reg)
                begin
                    // Gap moves left: the character just before it goes to its top end.
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(gap_low_reg - ONE_P);
                    state_next = S_MOVE_WR;
                end
                else if (gap_low_reg < cur_reg)
                begin
                    // Gap moves right: the character just after it goes to its bottom end.
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(gap_high_reg);
                    state_next = S_MOVE_WR;
                end
                else
                begin
                    unique case (cmd_reg)
                        gbte_pkg::CMD_INSERT:
                        begin
                            // The new character lands at the top of the gap, so the gap
                            // stays at the cursor afterward.
                            mem_we        = 1'b1;
                            mem_waddr     = AW'(gap_high_reg - ONE_P);
                            mem_wdata     = ch_reg;
                            gap_high_next = gap_high_reg - ONE_P;
                            state_next    = S_DONE;
                        end
                        gbte_pkg::CMD_DEL_BEFORE:
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = AW'(gap_low_reg - ONE_P);
                            gap_low_next = gap_low_reg - ONE_P;
                            state_next   = S_EDIT_CAP;
                        end
                        gbte_pkg::CMD_DEL_AT:
                        begin
                            mem_re        = 1'b1;
                            mem_raddr     = AW'(gap_high_reg);
                            gap_high_next = gap_high_reg + ONE_P;
                            state_next    = S_EDIT_CAP;
                        end
                        gbte_pkg::CMD_QUERY:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MOVE_WR:
            begin
                mem_we = 1'b1;
                if (gap_low_reg > cur_reg)
                begin
                    mem_waddr     = AW'(gap_high_reg - ONE_P);
                    gap_low_next  = gap_low_reg - ONE_P;
                    gap_high_next = gap_high_reg - ONE_P;
                end
                else
                begin
                    mem_waddr     = AW'(gap_low_reg);
                    gap_low_next  = gap_low_reg + ONE_P;
                    gap_high_next = gap_high_reg + ONE_P;
                end
                state_next = S_MOVE_RD;
            end

            S_EDIT_CAP:
            begin
                ch_out_next = rd_data_reg;
                state_next  = S_DONE;
            end

            S_BK_RD:
            begin
                if (p_reg == '0)
                begin
                    bk_fin = 1'b1;
                    bk_val = '0;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_BK_CHK;
                end
            end

            S_BK_CHK:
            begin
                if (rd_data_reg == gbte_pkg::NEWLINE_CH)
                begin
                    bk_fin = 1'b1;
                    bk_val = p_reg;
                end
                else
                begin
                    p_next     = p_reg - ONE_P;
                    state_next = S_BK_RD;
                end
            end

            S_FW_RD:
            begin
                if (p_reg == text_len)
                begin
                    fw_fin = 1'b1;
                    fw_val = text_len;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_FW_CHK;
                end
            end

            S_FW_CHK:
            begin
                if (p_reg == cur_reg)
                begin
                    ch_out_next = rd_data_reg;
                end
                if (rd_data_reg == gbte_pkg::NEWLINE_CH)
                begin
                    fw_fin = 1'b1;
                    fw_val = p_reg;
                end
                else
                begin
                    p_next     = p_reg + ONE_P;
                    state_next = S_FW_RD;
                end
            end

            S_DONE:
            begin
                tl_next        = OW'(text_len);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of a backward scan: the first one gives the line start, the second one the start
        // of the previous line, after which all query fields are known.
        if (bk_fin)
        begin
            if (!second_reg)
            begin
                b_next     = bk_val;
                ps_next    = (bk_val != '0) ? (bk_val - ONE_P) : '0;
                p_next     = cur_reg;
                state_next = S_FW_RD;
            end
            else
            begin
                lb_next    = OW'(b_reg);
                ls_next    = OW'(e_reg);
                col_next   = OW'(cur_reg - b_reg);
                ll_next    = OW'(e_reg - b_reg);
                nlb_next   = (e_reg < text_len) ? OW'(e_reg + ONE_P) : OW'(e_reg);
                pls_next   = OW'(ps_reg);
                plb_next   = OW'(bk_val);
                state_next = S_DONE;
            end
        end

        // End of the forward scan: the line end is known; scan back from the previous line end.
        if (fw_fin)
        begin
            e_next      = fw_val;
            p_next      = ps_reg;
            second_next = 1'b1;
            state_next  = S_BK_RD;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gap_low_reg   <= '0;
            gap_high_reg  <= CAP_P;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gap_low_reg   <= gap_low_next;
            gap_high_reg  <= gap_high_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // Command, scan and result payload.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        ch_reg     <= ch_next;
        p_reg      <= p_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        ps_reg     <= ps_next;
        status_reg <= status_next;
        ch_out_reg <= ch_out_next;
        tl_reg     <= tl_next;
        lb_reg     <= lb_next;
        ls_reg     <= ls_next;
        col_reg    <= col_next;
        ll_reg     <= ll_next;
        nlb_reg    <= nlb_next;
        pls_reg    <= pls_next;
        plb_reg    <= plb_next;
    end

    // Text store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign ch_out          = ch_out_reg;
    assign text_length     = tl_reg;
    assign line_begin      = lb_reg;
    assign line_stop       = ls_reg;
    assign column          = col_reg;
    assign line_length     = ll_reg;
    assign next_line_begin = nlb_reg;
    assign prev_line_stop  = pls_reg;
    assign prev_line_begin = plb_reg;

endmodule

FILE: sim/gap_buffer_text_editor_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the gap-buffer text editor core with a shadow text model.
module gap_buffer_text_editor_core_tb;

    localparam int CAPACITY     = 4096;
    localparam int CLK_PERIOD   = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_POS      = (1 << gbte_pkg::POS_W) - 1;

    // One expected result transaction, field for field as the core reports it.
    typedef struct packed {
        logic [gbte_pkg::STAT_W-1:0] status;
        logic [gbte_pkg::CH_W-1:0]   ch_out;
        logic [gbte_pkg::POS_W-1:0]  text_length;
        logic [gbte_pkg::POS_W-1:0]  line_begin;
        logic [gbte_pkg::POS_W-1:0]  line_stop;
        logic [gbte_pkg::POS_W-1:0]  column;
        logic [gbte_pkg::POS_W-1:0]  line_length;
        logic [gbte_pkg::POS_W-1:0]  next_line_begin;
        logic [gbte_pkg::POS_W-1:0]  prev_line_stop;
        logic [gbte_pkg::POS_W-1:0]  prev_line_begin;
    } edit_result_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [gbte_pkg::CMD_W-1:0]  cmd = gbte_pkg::CMD_QUERY;
    logic [gbte_pkg::POS_W-1:0]  cursor = '0;
    logic [gbte_pkg::CH_W-1:0]   ch = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [gbte_pkg::STAT_W-1:0] status;
    logic [gbte_pkg::CH_W-1:0]   ch_out;
    logic [gbte_pkg::POS_W-1:0]  text_length;
    logic [gbte_pkg::POS_W-1:0]  line_begin;
    logic [gbte_pkg::POS_W-1:0]  line_stop;
    logic [gbte_pkg::POS_W-1:0]  column;
    logic [gbte_pkg::POS_W-1:0]  line_length;
    logic [gbte_pkg::POS_W-1:0]  next_line_begin;
    logic [gbte_pkg::POS_W-1:0]  prev_line_stop;
    logic [gbte_pkg::POS_W-1:0]  prev_line_begin;

    // The text as the user sees it, in logical order. The gap inside the core is an
    // implementation detail, so the shadow copy keeps only the logical characters.
    logic [gbte_pkg::CH_W-1:0] shadow_text[$];
    edit_result_t              expected_results[$];

    // Percentages that shape the idle behavior of both channels in each phase.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // Remaining cycles of a forced hold-off on the result channel.
    int hold_left     = 0;
    // Where the simulated user is typing; random edits mostly stay near it.
    int edit_point    = 0;
    int error_count   = 0;

    gap_buffer_text_editor_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .cursor(cursor),
        .ch(ch),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .ch_out(ch_out),
        .text_length(text_length),
        .line_begin(line_begin),
        .line_stop(line_stop),
        .column(column),
        .line_length(line_length),
        .next_line_begin(next_line_begin),
        .prev_line_stop(prev_line_stop),
        .prev_line_begin(prev_line_begin)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The run must end even if the core hangs. The bound is several times the
    // slowest legal run, including the full-store fill and the long hold-off.
    initial
    begin
        #60_000_000;
        $display("gap_buffer_text_editor_core test failed");
        $finish;
    end

    // Scans left from a position to the first character after a newline.
    function automatic int line_head(int p);
        while (p > 0)
        begin
            if (shadow_text[p - 1] == gbte_pkg::NEWLINE_CH)
                return p;
            p--;
        end
        return 0;
    endfunction

    // Scans right from a position to the next newline or the end of the text.
    function automatic int line_tail(int p);
        int len;
        len = shadow_text.size();
        while (p < len)
        begin
            if (shadow_text[p] == gbte_pkg::NEWLINE_CH)
                return p;
            p++;
        end
        return len;
    endfunction

    // Applies one command to the shadow text and returns the result the core must report.
    function automatic edit_result_t apply_edit(logic [gbte_pkg::CMD_W-1:0] op, int pos,
                                                logic [gbte_pkg::CH_W-1:0] c);
        edit_result_t r;
        int len;
        int b;
        int e;
        int ps;
        r = '0;
        len = shadow_text.size();
        if (pos > len)
        begin
            // A cursor past the end of the text rejects every command.
            r.status = gbte_pkg::STAT_CURSOR;
        end
        else
        begin
            case (op)
                gbte_pkg::CMD_INSERT:
                begin
                    if (len >= CAPACITY)
                        r.status = gbte_pkg::STAT_FULL;
                    else
                        shadow_text.insert(pos, c);
                end
                gbte_pkg::CMD_DEL_BEFORE:
                begin
                    if (pos == 0)
                    begin
                        r.status = gbte_pkg::STAT_BOUNDARY;
                    end
                    else
                    begin
                        r.ch_out = shadow_text[pos - 1];
                        shadow_text.delete(pos - 1);
                    end
                end
                gbte_pkg::CMD_DEL_AT:
                begin
                    // At the end of the text there is nothing to remove; the core
                    // reports the no-character code in that case.
                    if (pos == len)
                    begin
                        r.status = gbte_pkg::STAT_BOUNDARY;
                        r.ch_out = gbte_pkg::NO_CHAR;
                    end
                    else
                    begin
                        r.ch_out = shadow_text[pos];
                        shadow_text.delete(pos);
                    end
                end
                default:
                begin
                    b = line_head(pos);
                    e = line_tail(pos);
                    ps = (b > 0) ? b - 1 : 0;
                    r.ch_out = (pos < len) ? shadow_text[pos] : gbte_pkg::NO_CHAR;
                    r.line_begin = gbte_pkg::POS_W'(b);
                    r.line_stop = gbte_pkg::POS_W'(e);
                    r.column = gbte_pkg::POS_W'(pos - b);
                    r.line_length = gbte_pkg::POS_W'(e - b);
                    r.next_line_begin = gbte_pkg::POS_W'((e < len) ? e + 1 : e);
                    r.prev_line_stop = gbte_pkg::POS_W'(ps);
                    r.prev_line_begin = gbte_pkg::POS_W'(line_head(ps));
                end
            endcase
        end
        r.text_length = gbte_pkg::POS_W'(shadow_text.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch(what, int'(got), int'(want));
    endtask

    // Offers one command transaction, optionally after some idle cycles, and waits
    // until the core takes it. The expected result is computed at acceptance, so the
    // shadow text always follows the order in which the core executes commands.
    // Valid stays high after acceptance when the next command follows at once.
    task automatic send_edit(logic [gbte_pkg::CMD_W-1:0] op, int pos,
                             logic [gbte_pkg::CH_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        cursor <= pos[gbte_pkg::POS_W-1:0];
        ch <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_edit(op, pos & MAX_POS, c));
    endtask

    // Typed characters: mostly arbitrary bytes, with enough newlines to keep lines short.
    function automatic logic [gbte_pkg::CH_W-1:0] rand_char();
        if ($urandom_range(99) < 12)
            return gbte_pkg::NEWLINE_CH;
        return gbte_pkg::CH_W'($urandom_range(255));
    endfunction

    // Random editing session. Most commands land near the current edit point, as a
    // user would type, which keeps gap moves short; some jump to the text ends or
    // beyond them. The insert share falls as the text grows so its length stays modest.
    task automatic random_edits(int count);
        int len;
        int pos;
        int pick;
        int insert_share;
        logic [gbte_pkg::CMD_W-1:0] op;
        repeat (count)
        begin
            len = shadow_text.size();
            pick = $urandom_range(99);
            if (pick < 6)
                pos = $urandom_range(MAX_POS);
            else if (pick < 10)
                pos = len + 1 + $urandom_range(3);
            else if (pick < 16)
                pos = len;
            else if (pick < 22)
                pos = 0;
            else
                pos = edit_point + $urandom_range(8) - 4;
            if (pos < 0)
                pos = 0;
            if (pick >= 22 && pos > len)
                pos = len;

            insert_share = (len < 30) ? 60 : (len > 250) ? 20 : 40;
            if ($urandom_range(99) < insert_share)
            begin
                op = gbte_pkg::CMD_INSERT;
            end
            else
            begin
                case ($urandom_range(2))
                    0: op = gbte_pkg::CMD_DEL_BEFORE;
                    1: op = gbte_pkg::CMD_DEL_AT;
                    default: op = gbte_pkg::CMD_QUERY;
                endcase
            end

            send_edit(op, pos, rand_char());
            if (pos <= shadow_text.size())
                edit_point = pos;
        end
    endtask

    // Result channel stall generator. A forced hold-off takes priority over the
    // random stall and is counted down here, independent of the command sender.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Every accepted result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        edit_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with none expected", int'(status), 0);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 16'(status), 16'(want.status));
                check_field("ch_out", 16'(ch_out), 16'(want.ch_out));
                check_field("text_length", 16'(text_length), 16'(want.text_length));
                check_field("line_begin", 16'(line_begin), 16'(want.line_begin));
                check_field("line_stop", 16'(line_stop), 16'(want.line_stop));
                check_field("column", 16'(column), 16'(want.column));
                check_field("line_length", 16'(line_length), 16'(want.line_length));
                check_field("next_line_begin", 16'(next_line_begin),
                            16'(want.next_line_begin));
                check_field("prev_line_stop", 16'(prev_line_stop),
                            16'(want.prev_line_stop));
                check_field("prev_line_begin", 16'(prev_line_begin),
                            16'(want.prev_line_begin));
            end
        end
    end

    // Commands on an empty text: every boundary case and cursors far past the end.
    task automatic test_empty_text();
        send_edit(gbte_pkg::CMD_QUERY, 0, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_BEFORE, 0, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_AT, 0, 8'h00);
        send_edit(gbte_pkg::CMD_INSERT, 1, 8'hFF);
        send_edit(gbte_pkg::CMD_QUERY, MAX_POS, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_AT, CAPACITY, 8'h00);
    endtask

    // Builds a short text with an empty line and a leading newline, then queries
    // each interesting position and exercises both deletes, including at the ends.
    task automatic test_line_queries();
        send_edit(gbte_pkg::CMD_INSERT, 0, "a");
        send_edit(gbte_pkg::CMD_INSERT, 1, "c");
        send_edit(gbte_pkg::CMD_INSERT, 1, "b");
        send_edit(gbte_pkg::CMD_INSERT, 3, gbte_pkg::NEWLINE_CH);
        send_edit(gbte_pkg::CMD_INSERT, 4, gbte_pkg::NEWLINE_CH);
        send_edit(gbte_pkg::CMD_INSERT, 5, "d");
        send_edit(gbte_pkg::CMD_INSERT, 0, gbte_pkg::NEWLINE_CH);
        send_edit(gbte_pkg::CMD_QUERY, 0, 8'h00);
        send_edit(gbte_pkg::CMD_QUERY, 2, 8'h00);
        send_edit(gbte_pkg::CMD_QUERY, 5, 8'h00);
        send_edit(gbte_pkg::CMD_QUERY, 6, 8'h00);
        send_edit(gbte_pkg::CMD_QUERY, 7, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_BEFORE, 5, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_AT, 0, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_AT, shadow_text.size(), 8'h00);
        send_edit(gbte_pkg::CMD_DEL_BEFORE, shadow_text.size(), 8'h00);
        edit_point = shadow_text.size();
    endtask

    // Fills the store to capacity by appending, then checks the full-store rejection
    // and the commands at the very end and in the middle of a full text.
    task automatic test_full_store();
        send_idle_pct = 0;
        stall_pct = 0;
        while (shadow_text.size() < CAPACITY)
            send_edit(gbte_pkg::CMD_INSERT, shadow_text.size(), rand_char());
        send_edit(gbte_pkg::CMD_INSERT, 100, "x");
        send_edit(gbte_pkg::CMD_INSERT, CAPACITY, "x");
        send_edit(gbte_pkg::CMD_QUERY, CAPACITY, 8'h00);
        send_edit(gbte_pkg::CMD_DEL_AT, CAPACITY, 8'h00);
        send_edit(gbte_pkg::CMD_QUERY, CAPACITY + 1, 8'h00);
        // A delete in the middle moves the whole upper half across the gap.
        send_edit(gbte_pkg::CMD_DEL_AT, CAPACITY / 2, 8'h00);
        send_edit(gbte_pkg::CMD_INSERT, CAPACITY / 2, "y");
        send_edit(gbte_pkg::CMD_QUERY, CAPACITY / 2, 8'h00);
        send_edit(gbte_pkg::CMD_INSERT, 0, "z");
    endtask

    // The result channel holds off for a long stretch while commands keep coming,
    // so the core must stall its command channel until the stretch ends.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left <= HOLD_CYCLES;
        random_edits(16);
    endtask

    // Random editing under each idle pattern of the two channels.
    task automatic test_random_phases();
        send_idle_pct = 0;
        stall_pct = 0;
        random_edits(400);
        send_idle_pct = 77;
        stall_pct = 0;
        random_edits(400);
        send_idle_pct = 0;
        stall_pct = 77;
        random_edits(400);
        send_idle_pct = 33;
        stall_pct = 33;
        random_edits(400);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_text();
        test_line_queries();
        test_back_pressure();
        test_random_phases();
        test_full_store();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // A late extra result would show up within a few cycles of the last one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("gap_buffer_text_editor_core test passed");
        else
            $display("gap_buffer_text_editor_core test failed");
        $finish;
    end

endmodule

FILE: gap_buffer_text_editor_core.f
rtl/gbte_pkg.sv
rtl/gap_buffer_text_editor_core.sv
sim/gap_buffer_text_editor_core_tb.sv
